// ===== hdl/pvt_pkg.sv =====
// Shared types and constants for the page replacement victim table.
`timescale 1ns / 1ps

package pvt_pkg;

	localparam int PAGE_W     = 20;
	localparam int FRAME_W    = 8;
	localparam int IN_REF_W   = 16;
	localparam int OCC_W      = 7;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 40;
	localparam int CMD_W      = 2;
	localparam int STAT_W     = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_EVICT  = 2'd2,
		CMD_UPDATE = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_FETCH,
		S_CHECK,
		S_SH_RD,
		S_SH_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic    load;
		logic    ins_wr;
		logic    rd_en;
		logic    rd_next;
		logic    take;
		logic    ptr_inc;
		logic    ptr_idx;
		logic    upd_wr;
		logic    sh_wr;
		logic    cnt_dec;
		logic    set_st;
		status_t st;
		logic    res_load;
	} ctl_t;

	typedef struct packed {
		cmd_t cmd;
		logic cnt_zero;
		logic cnt_full;
		logic ptr_zero;
		logic ptr_last;
		logic match;
		logic less;
		logic out_free;
	} sts_t;

endpackage

// ===== hdl/pvt_ctrl.sv =====
// Controller state machine for the page replacement victim table.
`timescale 1ns / 1ps

module pvt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  pvt_pkg::sts_t sts,
	output pvt_pkg::ctl_t ctl
);

	pvt_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pvt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pvt_pkg::S_IDLE: begin
				if (s_tvalid) begin
					state_d = pvt_pkg::S_DECIDE;
				end
			end
			pvt_pkg::S_DECIDE: begin
				if (sts.cmd == pvt_pkg::CMD_INSERT || sts.cnt_zero) begin
					state_d = pvt_pkg::S_DONE;
				end else begin
					state_d = pvt_pkg::S_FETCH;
				end
			end
			pvt_pkg::S_FETCH: begin
				state_d = pvt_pkg::S_CHECK;
			end
			pvt_pkg::S_CHECK: begin
				unique case (sts.cmd)
					pvt_pkg::CMD_REMOVE: begin
						if (sts.match) begin
							state_d = pvt_pkg::S_SH_RD;
						end else if (sts.ptr_last) begin
							state_d = pvt_pkg::S_DONE;
						end else begin
							state_d = pvt_pkg::S_FETCH;
						end
					end
					pvt_pkg::CMD_UPDATE: begin
						if (sts.match || sts.ptr_last) begin
							state_d = pvt_pkg::S_DONE;
						end else begin
							state_d = pvt_pkg::S_FETCH;
						end
					end
					pvt_pkg::CMD_EVICT: begin
						if (sts.ptr_last) begin
							state_d = pvt_pkg::S_SH_RD;
						end else begin
							state_d = pvt_pkg::S_FETCH;
						end
					end
					default: begin
						state_d = pvt_pkg::S_DONE;
					end
				endcase
			end
			pvt_pkg::S_SH_RD: begin
				if (sts.ptr_last) begin
					state_d = pvt_pkg::S_DONE;
				end else begin
					state_d = pvt_pkg::S_SH_WR;
				end
			end
			pvt_pkg::S_SH_WR: begin
				state_d = pvt_pkg::S_SH_RD;
			end
			pvt_pkg::S_DONE: begin
				if (sts.out_free) begin
					state_d = pvt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pvt_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl      = '0;
		ctl.st   = pvt_pkg::ST_OK;
		s_tready = 1'b0;
		unique case (state_q)
			pvt_pkg::S_IDLE: begin
				s_tready = 1'b1;
				ctl.load = s_tvalid;
			end
			pvt_pkg::S_DECIDE: begin
				ctl.set_st = 1'b1;
				unique case (sts.cmd)
					pvt_pkg::CMD_INSERT: begin
						if (sts.cnt_full) begin
							ctl.st = pvt_pkg::ST_FULL;
						end else begin
							ctl.ins_wr = 1'b1;
						end
					end
					pvt_pkg::CMD_EVICT: begin
						if (sts.cnt_zero) begin
							ctl.st = pvt_pkg::ST_EMPTY;
						end
					end
					default: begin
						if (sts.cnt_zero) begin
							ctl.st = pvt_pkg::ST_NOT_FOUND;
						end
					end
				endcase
			end
			pvt_pkg::S_FETCH: begin
				ctl.rd_en = 1'b1;
			end
			pvt_pkg::S_CHECK: begin
				unique case (sts.cmd)
					pvt_pkg::CMD_REMOVE: begin
						if (sts.match) begin
							ctl.take = 1'b1;
						end else if (sts.ptr_last) begin
							ctl.set_st = 1'b1;
							ctl.st     = pvt_pkg::ST_NOT_FOUND;
						end else begin
							ctl.ptr_inc = 1'b1;
						end
					end
					pvt_pkg::CMD_UPDATE: begin
						if (sts.match) begin
							ctl.upd_wr = 1'b1;
						end else if (sts.ptr_last) begin
							ctl.set_st = 1'b1;
							ctl.st     = pvt_pkg::ST_NOT_FOUND;
						end else begin
							ctl.ptr_inc = 1'b1;
						end
					end
					pvt_pkg::CMD_EVICT: begin
						ctl.take = sts.ptr_zero || sts.less;
						if (sts.ptr_last) begin
							ctl.ptr_idx = 1'b1;
						end else begin
							ctl.ptr_inc = 1'b1;
						end
					end
					default: begin
						ctl.set_st = 1'b0;
					end
				endcase
			end
			pvt_pkg::S_SH_RD: begin
				if (sts.ptr_last) begin
					ctl.cnt_dec = 1'b1;
				end else begin
					ctl.rd_en   = 1'b1;
					ctl.rd_next = 1'b1;
				end
			end
			pvt_pkg::S_SH_WR: begin
				ctl.sh_wr   = 1'b1;
				ctl.ptr_inc = 1'b1;
			end
			pvt_pkg::S_DONE: begin
				ctl.res_load = sts.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

// ===== hdl/pvt_datapath.sv =====
// Entry memory, scan pointer, victim registers and result register.
`timescale 1ns / 1ps

module pvt_datapath #(
	parameter int ENTRIES  = 64,
	parameter int REF_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pvt_pkg::ctl_t                     ctl,
	output pvt_pkg::sts_t                     sts,
	// page_id[19:0], frame_in[27:20], reference_count[43:28], modified_in[44]
	input  logic [pvt_pkg::IN_DATA_W-1:0]     s_tdata,
	// command[1:0]
	input  logic [pvt_pkg::CMD_W-1:0]         s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// page_out[19:0], frame_out[27:20], write_back[28], occupancy[35:29]
	output logic [pvt_pkg::OUT_DATA_W-1:0]    m_tdata,
	// status[1:0]
	output logic [pvt_pkg::STAT_W-1:0]        m_tuser
);

	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int WORD_W = pvt_pkg::PAGE_W + pvt_pkg::FRAME_W + 1 + REF_BITS;
	localparam int DIRTY_B = pvt_pkg::PAGE_W + pvt_pkg::FRAME_W;
	localparam int REFS_B  = DIRTY_B + 1;
	localparam int PAD_W  = pvt_pkg::OUT_DATA_W - pvt_pkg::PAGE_W - pvt_pkg::FRAME_W - 1
		- pvt_pkg::OCC_W;

	logic [WORD_W-1:0] mem [ENTRIES];

	logic [WORD_W-1:0]           rd_data_q;
	logic [IDX_W-1:0]            rd_addr;
	logic                        wr_en;
	logic [IDX_W-1:0]            wr_addr;
	logic [WORD_W-1:0]           wr_data;

	logic [CNT_W-1:0]            count_q;
	logic [IDX_W-1:0]            ptr_q;
	logic [IDX_W-1:0]            idx_q;
	pvt_pkg::cmd_t               cmd_q;
	logic [pvt_pkg::PAGE_W-1:0]  id_q;
	logic [pvt_pkg::FRAME_W-1:0] frame_q;
	logic [REF_BITS-1:0]         refs_q;
	logic                        dirty_q;
	pvt_pkg::status_t            st_q;

	logic [REF_BITS-1:0]         best_q;
	logic [pvt_pkg::PAGE_W-1:0]  vic_page_q;
	logic [pvt_pkg::FRAME_W-1:0] vic_frame_q;
	logic                        vic_dirty_q;

	logic                        m_tvalid_q;
	logic [pvt_pkg::OUT_DATA_W-1:0] m_tdata_q;
	logic [pvt_pkg::STAT_W-1:0]  m_tuser_q;

	logic [pvt_pkg::PAGE_W-1:0]  rd_page;
	logic [pvt_pkg::FRAME_W-1:0] rd_frame;
	logic [REF_BITS-1:0]         rd_refs;
	logic                        out_free;
	logic                        give_victim;

	assign rd_page  = rd_data_q[pvt_pkg::PAGE_W-1:0];
	assign rd_frame = rd_data_q[DIRTY_B-1:pvt_pkg::PAGE_W];
	assign rd_refs  = rd_data_q[REFS_B +: REF_BITS];
	assign out_free = !m_tvalid_q || m_tready;

	assign rd_addr = ctl.rd_next ? IDX_W'(ptr_q + IDX_W'(1)) : ptr_q;

	always_comb begin
		wr_en   = ctl.ins_wr || ctl.upd_wr || ctl.sh_wr;
		wr_addr = ptr_q;
		wr_data = rd_data_q;
		if (ctl.ins_wr) begin
			wr_addr = IDX_W'(count_q);
			wr_data = {refs_q, dirty_q, frame_q, id_q};
		end else if (ctl.upd_wr) begin
			wr_data = {refs_q, dirty_q, rd_frame, rd_page};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			id_q    <= s_tdata[19:0];
			frame_q <= s_tdata[27:20];
			refs_q  <= REF_BITS'(s_tdata[43:28]);
			dirty_q <= s_tdata[44];
		end
		if (ctl.take) begin
			best_q      <= rd_refs;
			vic_page_q  <= rd_page;
			vic_frame_q <= rd_frame;
			vic_dirty_q <= rd_data_q[DIRTY_B];
		end
		if (ctl.res_load) begin
			m_tdata_q <= give_victim
				? {PAD_W'(0), pvt_pkg::OCC_W'(count_q), vic_dirty_q, vic_frame_q, vic_page_q}
				: {PAD_W'(0), pvt_pkg::OCC_W'(count_q), 1'b0, pvt_pkg::FRAME_W'(0),
					pvt_pkg::PAGE_W'(0)};
			m_tuser_q <= st_q;
		end
	end

	assign give_victim = (st_q == pvt_pkg::ST_OK)
		&& (cmd_q == pvt_pkg::CMD_REMOVE || cmd_q == pvt_pkg::CMD_EVICT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			ptr_q      <= '0;
			idx_q      <= '0;
			cmd_q      <= pvt_pkg::CMD_INSERT;
			st_q       <= pvt_pkg::ST_OK;
			m_tvalid_q <= 1'b0;
		end else begin
			if (ctl.load) begin
				cmd_q <= pvt_pkg::cmd_t'(s_tuser);
				st_q  <= pvt_pkg::ST_OK;
			end
			if (ctl.set_st) begin
				st_q <= ctl.st;
			end
			if (ctl.load) begin
				ptr_q <= '0;
			end else if (ctl.ptr_inc) begin
				ptr_q <= ptr_q + IDX_W'(1);
			end else if (ctl.ptr_idx && !ctl.take) begin
				ptr_q <= idx_q;
			end
			if (ctl.take) begin
				idx_q <= ptr_q;
			end
			if (ctl.ins_wr) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.cnt_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (ctl.res_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.cmd      = cmd_q;
		sts.cnt_zero = (count_q == '0);
		sts.cnt_full = (count_q == CNT_W'(ENTRIES));
		sts.ptr_zero = (ptr_q == '0);
		sts.ptr_last = ((CNT_W'(ptr_q) + CNT_W'(1)) >= count_q);
		sts.match    = (rd_page == id_q);
		sts.less     = (rd_refs < best_q);
		sts.out_free = out_free;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("entry count above capacity");

	a_no_ins_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins_wr |-> count_q != CNT_W'(ENTRIES))
		else $error("insert write into full table");

	a_no_dec_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.cnt_dec |-> count_q != '0)
		else $error("entry count underflow");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.ins_wr, ctl.upd_wr, ctl.sh_wr}))
		else $error("conflicting memory writes");

	a_load_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.res_load |-> out_free)
		else $error("result register overwritten while held");

endmodule

// ===== hdl/page_replacement_victim_table.sv =====
// Top level of the page replacement victim table: LFU victim selection over an ordered table.
// Insert, and any command on an empty table, finishes without a scan; update, remove and evict
// scan the entries in order, and remove and evict then shift the later entries down one place.
// One item in flight; the next item is taken the cycle after its result is registered.
// The entry memory has separate read and write addresses; the controller never reads and writes it in one state.
// Reset clears the entry count, controller state and output valid; entries need no clearing.
`timescale 1ns / 1ps

module page_replacement_victim_table #(
	parameter int ENTRIES  = 64,
	parameter int REF_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// page_id[19:0], frame_in[27:20], reference_count[43:28], modified_in[44]
	input  logic [pvt_pkg::IN_DATA_W-1:0]  s_tdata,
	// command[1:0]
	input  logic [pvt_pkg::CMD_W-1:0]      s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// page_out[19:0], frame_out[27:20], write_back[28], occupancy[35:29]
	output logic [pvt_pkg::OUT_DATA_W-1:0] m_tdata,
	// status[1:0]
	output logic [pvt_pkg::STAT_W-1:0]     m_tuser
);

	pvt_pkg::ctl_t ctl;
	pvt_pkg::sts_t sts;

	pvt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	pvt_datapath #(
		.ENTRIES  (ENTRIES),
		.REF_BITS (REF_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
